// ===== src/bitp_pkg.sv =====
// Shared types, constants and helper functions for the bounded integer text parser.
// Depends on nothing; every other file of the block imports it.
package bitp_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned RADIX_W     = 6;
    localparam int unsigned DIGIT_W     = 8;
    localparam int unsigned OFFSET_W    = 16;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned CFG_IDX_W   = 2;

    // Depth of the byte queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Radix values with a meaning of their own.
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_ONE    = 6'd1;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

    // Character codes.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] LETTER_OFS = 8'd87;
    localparam logic [7:0] NOT_DIGIT  = 8'd99;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_BASE,
        ST_NONE,
        ST_TRAILING,
        ST_RANGE
    } status_t;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_STOPPED,
        PH_BADBASE
    } phase_t;

    typedef enum logic {
        SEQ_RUN,
        SEQ_DIV
    } seq_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [DATA_W-1:0]  low_limit;
        logic [DATA_W-1:0]  high_limit;
    } cfg_t;

    // One byte after classification by the front.
    typedef struct packed {
        logic               is_nul;
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic [DIGIT_W-1:0] dval;
    } byte_class_t;

    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DATA_W-1:0]  quotient;
        logic [RADIX_W-1:0] remainder;
    } div_rsp_t;

    // Digit value of a byte; letters of either case count from ten.
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
        logic [7:0] u;
        u = c | CASE_BIT;
        if (u >= CH_A_LOWER)
            return u - LETTER_OFS;
        else if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        else
            return NOT_DIGIT;
    endfunction

    function automatic byte_class_t classify(input logic [7:0] c);
        byte_class_t k;
        k.is_nul   = (c == CH_NUL);
        k.is_space = (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
        k.is_minus = (c == CH_MINUS);
        k.is_plus  = (c == CH_PLUS);
        k.is_zero  = (c == CH_ZERO);
        k.is_x     = ((c | CASE_BIT) == CH_X_LOWER);
        k.dval     = digit_value(c);
        return k;
    endfunction

endpackage

// ===== src/bitp_front.sv =====
// Front of the parser: takes text bytes, classifies them and queues them for the back.
// Depends on bitp_pkg.
module bitp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            text_byte,
    output logic                  full,
    output logic                  q_valid,
    output bitp_pkg::byte_class_t q_item,
    input  logic                  q_take
);
    import bitp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    byte_class_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_en;
    logic               rd_en;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_take && q_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Each accepted beat is stored already classified.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= classify(text_byte);
    end

endmodule

// ===== src/bitp_div.sv =====
// Radix-2 restoring divider: splits a 64-bit limit by the base, one quotient bit a cycle.
// Depends on bitp_pkg.
module bitp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bitp_pkg::div_req_t req,
    output bitp_pkg::div_rsp_t rsp
);
    import bitp_pkg::*;

    localparam int unsigned STEPS = DATA_W;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [DATA_W-1:0]  quo_reg, quo_next;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [RADIX_W:0]   rem_shift;
    logic               fits;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DATA_W-1]};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = fits ? RADIX_W'(rem_shift - {1'b0, dvs_reg}) : RADIX_W'(rem_shift);
        quo_next  = {quo_reg[DATA_W-2:0], fits};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= CNT_W'(STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Dividend shifts into the quotient in place.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/bitp_back.sv =====
// Back of the parser: runs the per-string conversion and holds the finished result.
// Depends on bitp_pkg and bitp_div.
module bitp_back #(
    parameter longint unsigned MAX_TEXT_LEN = 65535
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bitp_pkg::cfg_t                       cfg,
    input  logic                                 q_valid,
    input  bitp_pkg::byte_class_t                q_item,
    output logic                                 q_take,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [bitp_pkg::DATA_W-1:0]   parsed_value,
    output logic        [bitp_pkg::OFFSET_W-1:0] end_offset,
    output logic        [bitp_pkg::STATUS_W-1:0] status
);
    import bitp_pkg::*;

    localparam int unsigned       POS_W   = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [POS_W-1:0]  MAX_POS = POS_W'(MAX_TEXT_LEN);

    // Per-string state.
    seq_t               seq_reg, seq_next;
    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0]  mag_reg, mag_next;
    logic               ovf_reg, ovf_next;
    logic               seen_reg, seen_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   stop_reg, stop_next;
    logic               pend_reg, pend_next;
    logic [DIGIT_W-1:0] pend_dval_reg, pend_dval_next;

    // Result holding register.
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    status_t            out_status_reg, out_status_next;

    // Working signals.
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    logic                      first_byte;
    logic                      bad_radix;
    phase_t                    phase_eff;
    logic [POS_W-1:0]          pos_inc;
    logic                      fix_go;
    logic [RADIX_W-1:0]        fix_val;
    logic [RADIX_W-1:0]        fix_base;
    logic                      sign_done;
    logic [RADIX_W-1:0]        sign_base;
    logic                      digit_want;
    logic                      digit_go;
    logic [DIGIT_W-1:0]        digit_dval;
    logic [DATA_W+RADIX_W-1:0] prod;
    logic [DATA_W-1:0]         mag_acc;
    logic                      ovf_hit;

    bitp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Radix check on the first byte of a string, and the saturating byte counter.
    assign first_byte = (pos_reg == '0) && (phase_reg == PH_SPACE);
    assign bad_radix  = (cfg.radix > RADIX_MAX) || (cfg.radix == BASE_ONE);
    assign phase_eff  = (first_byte && bad_radix) ? PH_BADBASE : phase_reg;
    assign pos_inc    = (pos_reg < MAX_POS) ? pos_reg + 1'b1 : MAX_POS;

    // Digit accumulate uses one multiplier; the limit compare checks against the split limit.
    assign prod    = mag_reg * base_reg;
    assign mag_acc = prod[DATA_W-1:0] + DATA_W'(digit_dval);
    assign ovf_hit = (mag_reg > div_rsp.quotient) ||
                     ((mag_reg == div_rsp.quotient) &&
                      (digit_dval > DIGIT_W'(div_rsp.remainder)));

    // Conversion sequencer: next state and result capture.
    always_comb
    begin
        seq_next        = seq_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        mag_next        = mag_reg;
        ovf_next        = ovf_reg;
        seen_next       = seen_reg;
        pos_next        = pos_reg;
        stop_next       = stop_reg;
        pend_next       = pend_reg;
        pend_dval_next  = pend_dval_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_value_next  = out_value_reg;
        out_offset_next = out_offset_reg;
        out_status_next = out_status_reg;
        q_take          = 1'b0;
        div_req         = '0;
        fix_go          = 1'b0;
        fix_val         = BASE_AUTO;
        fix_base        = BASE_DEC;
        sign_done       = 1'b0;
        sign_base       = BASE_AUTO;
        digit_want      = 1'b0;
        digit_go        = 1'b0;
        digit_dval      = q_item.dval;

        unique case (seq_reg)
            SEQ_DIV:
            begin
                // Limits are split; finish the digit that was waiting on them.
                if (div_rsp.done)
                begin
                    seq_next   = SEQ_RUN;
                    pend_next  = 1'b0;
                    digit_go   = pend_reg;
                    digit_dval = pend_dval_reg;
                end
            end
            SEQ_RUN:
            begin
                if (q_valid && q_item.is_nul)
                begin
                    // End of string: build the result once the holding register is free.
                    if (!out_valid_next)
                    begin
                        q_take          = 1'b1;
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_offset_next = '0;
                        if (phase_eff == PH_BADBASE)
                            out_status_next = ST_BAD_BASE;
                        else if (!seen_reg)
                            out_status_next = ST_NONE;
                        else
                        begin
                            out_value_next  = neg_reg ? DATA_W'(0) - mag_reg : mag_reg;
                            out_offset_next = OFFSET_W'(stop_reg);
                            if (ovf_reg)
                                out_status_next = ST_RANGE;
                            else if (stop_reg < pos_reg)
                                out_status_next = ST_TRAILING;
                            else
                                out_status_next = ST_OK;
                        end
                        phase_next = PH_SPACE;
                        neg_next   = 1'b0;
                        base_next  = BASE_AUTO;
                        mag_next   = '0;
                        ovf_next   = 1'b0;
                        seen_next  = 1'b0;
                        pos_next   = '0;
                        stop_next  = '0;
                        pend_next  = 1'b0;
                    end
                end
                else if (q_valid)
                begin
                    q_take     = 1'b1;
                    pos_next   = pos_inc;
                    phase_next = phase_eff;

                    unique case (phase_eff)
                        PH_SPACE:
                        begin
                            if (!q_item.is_space)
                            begin
                                neg_next = q_item.is_minus;
                                if (cfg.radix != BASE_AUTO)
                                begin
                                    fix_go  = 1'b1;
                                    fix_val = cfg.radix;
                                end
                                if (q_item.is_minus || q_item.is_plus)
                                    phase_next = PH_SIGNED;
                                else
                                begin
                                    sign_done = 1'b1;
                                    sign_base = cfg.radix;
                                end
                            end
                        end
                        PH_SIGNED:
                        begin
                            sign_done = 1'b1;
                            sign_base = base_reg;
                        end
                        PH_ZERO:
                        begin
                            if (q_item.is_x)
                            begin
                                if (base_reg == BASE_AUTO)
                                begin
                                    fix_go  = 1'b1;
                                    fix_val = BASE_HEX;
                                end
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                if (base_reg == BASE_AUTO)
                                begin
                                    fix_go  = 1'b1;
                                    fix_val = BASE_OCT;
                                end
                                digit_want = 1'b1;
                            end
                        end
                        PH_DIGITS:
                        begin
                            digit_want = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    // First byte after any sign: a leading zero may open a prefix.
                    if (sign_done)
                    begin
                        if (q_item.is_zero && (sign_base == BASE_AUTO || sign_base == BASE_HEX))
                        begin
                            seen_next  = 1'b1;
                            stop_next  = pos_inc;
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            if (sign_base == BASE_AUTO)
                            begin
                                fix_go  = 1'b1;
                                fix_val = BASE_DEC;
                            end
                            digit_want = 1'b1;
                        end
                    end

                    // Base is settled: split the magnitude limit and park any digit.
                    if (fix_go)
                    begin
                        fix_base         = (fix_val < 6'd2) ? BASE_DEC : fix_val;
                        base_next        = fix_base;
                        div_req.start    = 1'b1;
                        div_req.dividend = neg_next ? DATA_W'(0) - cfg.low_limit
                                                    : cfg.high_limit;
                        div_req.divisor  = fix_base;
                        seq_next         = SEQ_DIV;
                        pend_next        = digit_want;
                        pend_dval_next   = q_item.dval;
                    end
                    else
                    begin
                        digit_go = digit_want;
                    end
                end
            end
        endcase

        // Digit step: stop on a non-digit, else accumulate with a sticky limit check.
        if (digit_go)
        begin
            if (digit_dval >= DIGIT_W'(base_reg))
                phase_next = PH_STOPPED;
            else
            begin
                ovf_next   = ovf_reg || ovf_hit;
                mag_next   = mag_acc;
                seen_next  = 1'b1;
                stop_next  = pos_next;
                phase_next = PH_DIGITS;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_RUN;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            base_reg      <= BASE_AUTO;
            ovf_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mag_reg       <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            ovf_reg       <= ovf_next;
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            stop_reg      <= stop_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_dval_reg  <= pend_dval_next;
        out_value_reg  <= out_value_next;
        out_offset_reg <= out_offset_next;
        out_status_reg <= out_status_next;
    end

    assign empty        = !out_valid_reg;
    assign parsed_value = $signed(out_value_reg);
    assign end_offset   = out_offset_reg;
    assign status       = out_status_reg;

endmodule

// ===== src/bounded_integer_text_parser.sv =====
// Output: a result is on the ports the cycle after the back takes the zero byte, which was
// queued first. Throughput: one byte a cycle, except that once per string, when the base
// becomes fixed, the 64-step limit divider holds the back until done, and a zero byte waits
// while a result is unpopped; the 4-entry byte queue then takes up to four more bytes and
// raises full. Reset clears the queue, the string state and the result register; radix
// goes to 10, limits to the full signed 64-bit range. Uses bitp_pkg, bitp_front, bitp_back.
module bounded_integer_text_parser #(
    parameter longint unsigned MAX_TEXT_LEN = 65535
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic        [7:0]                     text_byte,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [bitp_pkg::DATA_W-1:0]    parsed_value,
    output logic        [bitp_pkg::OFFSET_W-1:0]  end_offset,
    output logic        [bitp_pkg::STATUS_W-1:0]  status,
    input  logic                                  cfg_write,
    input  logic        [bitp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [bitp_pkg::DATA_W-1:0]    cfg_data
);
    import bitp_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [DATA_W-1:0]  low_limit_reg;
    logic [DATA_W-1:0]  high_limit_reg;
    cfg_t               cfg;
    logic               q_valid;
    byte_class_t        q_item;
    logic               q_take;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            low_limit_reg  <= {1'b1, {(DATA_W-1){1'b0}}};
            high_limit_reg <= {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RADIX:      radix_reg      <= cfg_data[RADIX_W-1:0];
                REG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                REG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.radix      = radix_reg;
    assign cfg.low_limit  = low_limit_reg;
    assign cfg.high_limit = high_limit_reg;

    bitp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_take    (q_take)
    );

    bitp_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take),
        .empty        (empty),
        .pop          (pop),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .status       (status)
    );

endmodule

// ===== src/bitp_checker.sv =====
// Port-level checks for the bounded integer text parser, bound to the top level.
// Depends on bitp_pkg and bounded_integer_text_parser.
module bitp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  empty,
    input logic                                  pop,
    input logic signed [bitp_pkg::DATA_W-1:0]    parsed_value,
    input logic        [bitp_pkg::OFFSET_W-1:0]  end_offset,
    input logic        [bitp_pkg::STATUS_W-1:0]  status
);
    import bitp_pkg::*;

    // An edge taken under reset leaves no result showing at the next edge.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // A waiting result holds until it is popped.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(parsed_value) && $stable(end_offset)
                              && $stable(status)))
        else $error("waiting result changed or vanished");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= ST_RANGE))
        else $error("undefined status code");

    // Failed conversions carry a zero value and a zero offset.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_BAD_BASE || status == ST_NONE))
            |-> (parsed_value == '0 && end_offset == '0))
        else $error("failed conversion with nonzero value or offset");

endmodule

bind bounded_integer_text_parser bitp_checker u_bitp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .parsed_value (parsed_value),
    .end_offset   (end_offset),
    .status       (status)
);
